// ----- hdl/dctd_pkg.sv -----
`default_nettype none

package dctd_pkg;

    localparam int YEAR_W  = 13;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    // Counting starts from 1601-01-01, the first day of a 400-year Gregorian cycle.
    localparam int BASE_YEAR    = 1601;
    localparam int EPOCH_OFFSET = 134774;   // days from 1601-01-01 to 1970-01-01

    localparam int CYCLE_DAYS   = 146097;   // 400 years
    localparam int CENTURY_DAYS = 36524;    // 100 years without a 400-year leap day
    localparam int QUAD_DAYS    = 1461;     // 4 years, one leap day
    localparam int YEAR_DAYS    = 365;

    localparam int CYCLE_YEARS   = 400;
    localparam int CENTURY_YEARS = 100;
    localparam int QUAD_YEARS    = 4;

    localparam int MONTHS_PER_YEAR  = 12;
    localparam int LAST_QUAD        = 24;   // short final group of a century
    localparam int LAST_CENTURY     = 3;
    localparam int LEAP_YEAR_IN_QUAD = 3;

    localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11): len = DAY_W'(30);
            FEBRUARY: len = leap ? DAY_W'(29) : DAY_W'(28);
            default:  len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/day_count_to_date.sv -----
// Channel | Signals                                 | Direction
// input   | in_valid, in_stall, days_since_epoch    | beat in
// output  | out_valid, out_stall, year, month,      | beat out
//         | day_of_month                            |
//
// A beat runs a long division of the day count by the 400-year length, then
// works out centuries, four-year groups and years, then steps through the
// months until it reaches the month that holds the date; the result is then
// presented and the sequencer goes back to idle. All steps share one
// subtractor. Reset clears the sequencer; in_stall is high from acceptance
// until the result beat has been taken, and a stalled result simply holds in
// its registers.

`default_nettype none

module day_count_to_date
    import dctd_pkg::*;
#(
    parameter int DAY_COUNT_BITS = 20
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [DAY_COUNT_BITS-1:0] days_since_epoch,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [YEAR_W-1:0]              year,
    output logic [MONTH_W-1:0]             month,
    output logic [DAY_W-1:0]               day_of_month
);

    localparam int REM_W   = DAY_COUNT_BITS + 2;
    localparam int Q_BITS  = DAY_COUNT_BITS - 15;
    localparam int CNT_W   = ($clog2(Q_BITS) > 3) ? $clog2(Q_BITS) : 3;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CYC  = 7'b0000010,
        S_CENT = 7'b0000100,
        S_QUAD = 7'b0001000,
        S_YEAR = 7'b0010000,
        S_MON  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [YEAR_W-1:0]    year_reg, year_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [1:0]           cidx_reg, cidx_next;
    logic [4:0]           gidx_reg, gidx_next;
    logic [1:0]           yidx_reg, yidx_next;

    logic [REM_W-1:0]     sub_op;
    logic [REM_W:0]       diff;
    logic                 fits;
    logic [31:0]          year_step;
    logic                 leap;
    logic [DAY_W-1:0]     mlen;

    assign leap = (yidx_reg == 2'(LEAP_YEAR_IN_QUAD))
               && ((gidx_reg != 5'(LAST_QUAD)) || (cidx_reg == 2'(LAST_CENTURY)));
    assign mlen = month_len(month_reg, leap);

    // The shared unit: one subtraction whose sign says whether the chunk fits.
    always_comb
    begin
        sub_op    = '0;
        year_step = '0;
        case (state_reg)
            S_CYC:
            begin
                sub_op    = REM_W'(CYCLE_DAYS) << cnt_reg;
                year_step = 32'(CYCLE_YEARS) << cnt_reg;
            end
            S_CENT:
            begin
                sub_op    = REM_W'(CENTURY_DAYS) << cnt_reg[0];
                year_step = 32'(CENTURY_YEARS) << cnt_reg[0];
            end
            S_QUAD:
            begin
                sub_op    = REM_W'(QUAD_DAYS) << cnt_reg;
                year_step = 32'(QUAD_YEARS) << cnt_reg;
            end
            S_YEAR:
            begin
                sub_op    = REM_W'(YEAR_DAYS) << cnt_reg[0];
                year_step = 32'(1) << cnt_reg[0];
            end
            S_MON:
            begin
                sub_op = REM_W'(mlen);
            end
            default:
            begin
                sub_op    = '0;
                year_step = '0;
            end
        endcase
    end

    assign diff = {1'b0, rem_reg} - {1'b0, sub_op};
    assign fits = ~diff[REM_W];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        year_next  = year_reg;
        month_next = month_reg;
        cidx_next  = cidx_reg;
        gidx_next  = gidx_reg;
        yidx_next  = yidx_reg;

        if ((state_reg == S_CYC) || (state_reg == S_CENT) || (state_reg == S_QUAD)
            || (state_reg == S_YEAR))
        begin
            if (fits)
            begin
                rem_next  = diff[REM_W-1:0];
                year_next = year_reg + year_step[YEAR_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next   = REM_W'(days_since_epoch) + REM_W'(EPOCH_OFFSET);
                    year_next  = YEAR_W'(BASE_YEAR);
                    cnt_next   = CNT_W'(Q_BITS - 1);
                    cidx_next  = '0;
                    gidx_next  = '0;
                    yidx_next  = '0;
                    state_next = S_CYC;
                end
            end
            S_CYC:
            begin
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(1);
                    state_next = S_CENT;
                end
            end
            S_CENT:
            begin
                cidx_next[cnt_reg[0]] = fits;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(4);
                    state_next = S_QUAD;
                end
            end
            S_QUAD:
            begin
                gidx_next[cnt_reg[2:0]] = fits;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(1);
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                yidx_next[cnt_reg[0]] = fits;
                if (cnt_reg == '0)
                begin
                    month_next = MONTH_W'(1);
                    state_next = S_MON;
                end
            end
            S_MON:
            begin
                if ((month_reg < MONTH_W'(MONTHS_PER_YEAR)) && fits)
                begin
                    rem_next   = diff[REM_W-1:0];
                    month_next = month_reg + MONTH_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        cidx_reg  <= cidx_next;
        gidx_reg  <= gidx_next;
        yidx_reg  <= yidx_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = (state_reg == S_DONE);
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = rem_reg[DAY_W-1:0] + DAY_W'(1);

endmodule

`default_nettype wire
